/* rtl/quaternion_alu_defines.svh */
// Assertion macros shared by the quaternion ALU RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef QUATERNION_ALU_DEFINES_SVH
`define QUATERNION_ALU_DEFINES_SVH

// Property checked every clock outside reset.
`define QALU_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define QALU_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/qalu_pkg.sv */
// Shared types, constants and helpers for the quaternion ALU.
// No dependencies.
package qalu_pkg;

  localparam int W    = 32;            // word width
  localparam int FRAC = 16;            // fraction bits
  localparam int AW   = 2 * W + 4;     // signed accumulator width
  localparam int SW   = 2 * W + 2;     // sum-of-squares magnitude width
  localparam int RW   = SW / 2;        // square root width
  localparam int NW   = W + 2 * FRAC;  // divider numerator width
  localparam int DW   = SW;            // divider divisor width
  localparam int CW   = $clog2(NW);    // iteration counter width

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_DIVS, OP_CONJ, OP_NORM, OP_LEN,
    OP_NRMZ, OP_INV, OP_EQ, OP_GE, OP_LE, OP_GT, OP_LT, OP_RSV
  } op_t;

  typedef enum logic [1:0] {ST_OK, ST_DIV0, ST_SAT} status_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MAC, B_DRAIN, B_SUM, B_POST, B_ROOT, B_RDONE, B_DIV, B_DDONE, B_OUT
  } bstate_t;

  typedef struct packed {
    logic       mac;   // goes through the multipliers
    logic [1:0] last;  // last multiply step
    logic       sum;   // needs the lane sum after the MAC
    logic       root;  // needs the square root
  } ctl_t;

  typedef struct packed {
    op_t               op;
    ctl_t              ctl;
    logic [3:0][W-1:0] a;
    logic [3:0][W-1:0] b;
    logic [W-1:0]      f;
  } item_t;

  typedef struct packed {
    logic [3:0][W-1:0] r;
    logic              cmp;
    status_t           st;
  } res_t;

  typedef struct packed {
    logic [W-1:0] w;
    logic         s;
  } satw_t;

  localparam logic signed [AW-1:0] WMAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] WMIN = ~WMAX;

  function automatic satw_t sat_acc(input logic signed [AW-1:0] v);
    satw_t o;
    if (v > WMAX) begin
      o.w = {1'b0, {(W-1){1'b1}}};
      o.s = 1'b1;
    end else if (v < WMIN) begin
      o.w = {1'b1, {(W-1){1'b0}}};
      o.s = 1'b1;
    end else begin
      o.w = v[W-1:0];
      o.s = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [W-1:0] abs_w(input logic [W-1:0] x);
    return x[W-1] ? (~x + W'(1)) : x;
  endfunction

  function automatic ctl_t classify(input op_t op);
    ctl_t c;
    c = '0;
    case (op)
      OP_MUL:                    begin c.mac = 1'b1; c.last = 2'd3; end
      OP_SCALE:                  c.mac = 1'b1;
      OP_NORM:                   begin c.mac = 1'b1; c.sum = 1'b1; end
      OP_LEN, OP_NRMZ:           begin c.mac = 1'b1; c.sum = 1'b1; c.root = 1'b1; end
      OP_INV:                    begin c.mac = 1'b1; c.sum = 1'b1; end
      OP_GE, OP_LE, OP_GT, OP_LT: begin c.mac = 1'b1; c.sum = 1'b1; c.last = 2'd1; end
      default:                   c = '0;
    endcase
    return c;
  endfunction

  // Hamilton product: term sign at step t for lane c
  function automatic logic ham_neg(input logic [1:0] t, input logic [1:0] c);
    return (t != 2'd0) && ((c == 2'd0) || (t == 2'd1 && c == 2'd2) ||
           (t == 2'd2 && c == 2'd3) || (t == 2'd3 && c == 2'd1));
  endfunction

endpackage

/* rtl/qalu_if.sv */
// Word channels of the quaternion ALU: operand and result interfaces.
// Depends on qalu_pkg.
interface qalu_in_if;
  import qalu_pkg::*;
  logic              valid;
  logic              ready;
  logic [3:0]        action;
  logic signed [W-1:0] a_scalar_part;
  logic signed [W-1:0] a_i_part;
  logic signed [W-1:0] a_j_part;
  logic signed [W-1:0] a_k_part;
  logic signed [W-1:0] b_scalar_part;
  logic signed [W-1:0] b_i_part;
  logic signed [W-1:0] b_j_part;
  logic signed [W-1:0] b_k_part;
  logic signed [W-1:0] factor;
  modport source (output valid, action, a_scalar_part, a_i_part, a_j_part, a_k_part,
                  b_scalar_part, b_i_part, b_j_part, b_k_part, factor, input ready);
  modport sink (input valid, action, a_scalar_part, a_i_part, a_j_part, a_k_part,
                b_scalar_part, b_i_part, b_j_part, b_k_part, factor, output ready);
endinterface

interface qalu_out_if;
  import qalu_pkg::*;
  logic              valid;
  logic              ready;
  logic signed [W-1:0] r_scalar_part;
  logic signed [W-1:0] r_i_part;
  logic signed [W-1:0] r_j_part;
  logic signed [W-1:0] r_k_part;
  logic              compare_true;
  logic [1:0]        status;
  modport source (output valid, r_scalar_part, r_i_part, r_j_part, r_k_part,
                  compare_true, status, input ready);
  modport sink (input valid, r_scalar_part, r_i_part, r_j_part, r_k_part,
                compare_true, status, output ready);
endinterface

/* rtl/qalu_front.sv */
// Front end: accepts operand words, classifies them, queues them (2 deep).
// Depends on qalu_pkg, qalu_if, quaternion_alu_defines.svh.
`include "quaternion_alu_defines.svh"
module qalu_front (
  input  logic            clk,
  input  logic            rst_n,
  qalu_in_if.sink         in_if,
  output logic            q_valid,
  output qalu_pkg::item_t q_item,
  input  logic            q_take
);
  import qalu_pkg::*;

  item_t       ent_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;
  item_t       nitem;

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_take && q_valid;
  assign q_item      = ent_r[rp_r];

  always_comb begin
    nitem.op  = op_t'(in_if.action);
    nitem.ctl = classify(op_t'(in_if.action));
    nitem.a   = {in_if.a_k_part, in_if.a_j_part, in_if.a_i_part, in_if.a_scalar_part};
    nitem.b   = {in_if.b_k_part, in_if.b_j_part, in_if.b_i_part, in_if.b_scalar_part};
    nitem.f   = in_if.factor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= nitem;
  end

  `QALU_CHK(a_cnt_range, cnt_r != 2'd3, "queue count out of range")
  `QALU_CHK_NEXT(a_push_only, push && !pop && cnt_r == 2'd1, cnt_r == 2'd2, "queue lost a word")
  `QALU_CHK_NEXT(a_pop_only, pop && !push && cnt_r == 2'd1, cnt_r == 2'd0, "queue kept a word")

endmodule

/* rtl/qalu_back.sv */
// Back end: multiplier/accumulator lanes, root and divide sequencer, output register.
// Depends on qalu_pkg, qalu_if, quaternion_alu_defines.svh.
`include "quaternion_alu_defines.svh"
module qalu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  qalu_pkg::item_t q_item,
  output logic            q_take,
  qalu_out_if.source      out_if
);
  import qalu_pkg::*;

  bstate_t                state_r, state_nxt;
  item_t                  it_r, it_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic signed [2*W-1:0]  p_r [4], p_nxt [4];
  logic                   pneg_r [4], pneg_nxt [4];
  logic                   pv_r, pv_nxt;
  logic signed [AW-1:0]   acc_r [4], acc_nxt [4];
  logic signed [AW-1:0]   tot_r, tot_nxt;
  logic [SW-1:0]          rad_r, rad_nxt;
  logic [RW+2:0]          rem_r, rem_nxt;
  logic [RW-1:0]          root_r, root_nxt;
  logic [NW-1:0]          num_r [4], num_nxt [4];
  logic                   dneg_r [4], dneg_nxt [4];
  logic [DW-1:0]          drem_r [4], drem_nxt [4];
  logic [DW-1:0]          dvs_r, dvs_nxt;
  res_t                   res_r, res_nxt;
  logic                   ov_r, ov_nxt;
  res_t                   out_r, out_nxt;

  always_comb begin
    logic signed [W-1:0]  mx, my;
    logic [1:0]           ci, ti;
    logic [W-1:0]         mag;
    satw_t                sv [4];
    logic                 sat_any;
    logic [RW+2:0]        remx, trial;
    logic [DW:0]          rx;
    logic                 go_div;
    logic [DW-1:0]        dv;
    logic                 dshift2;
    logic                 load_out;

    state_nxt = state_r;
    it_nxt    = it_r;
    cnt_nxt   = cnt_r;
    pv_nxt    = 1'b0;
    tot_nxt   = tot_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    dvs_nxt   = dvs_r;
    res_nxt   = res_r;
    q_take    = 1'b0;
    go_div    = 1'b0;
    dv        = '0;
    dshift2   = 1'b0;
    sat_any   = 1'b0;
    remx      = '0;
    trial     = '0;
    rx        = '0;
    mx        = '0;
    my        = '0;
    ci        = '0;
    ti        = '0;
    mag       = '0;
    for (int c = 0; c < 4; c++) begin
      p_nxt[c]    = p_r[c];
      pneg_nxt[c] = pneg_r[c];
      num_nxt[c]  = num_r[c];
      dneg_nxt[c] = dneg_r[c];
      drem_nxt[c] = drem_r[c];
      sv[c]       = '0;
      acc_nxt[c]  = pv_r ? acc_r[c] + (pneg_r[c] ? -AW'(p_r[c]) : AW'(p_r[c])) : acc_r[c];
    end

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_take  = 1'b1;
          it_nxt  = q_item;
          cnt_nxt = '0;
          res_nxt = '0;
          for (int c = 0; c < 4; c++) acc_nxt[c] = '0;
          if (q_item.ctl.mac) begin
            state_nxt = B_MAC;
          end else begin
            state_nxt = B_OUT;
            case (q_item.op)
              OP_ADD, OP_SUB: begin
                for (int c = 0; c < 4; c++) begin
                  sv[c] = sat_acc(q_item.op == OP_ADD ?
                      AW'($signed(q_item.a[c])) + AW'($signed(q_item.b[c])) :
                      AW'($signed(q_item.a[c])) - AW'($signed(q_item.b[c])));
                end
              end
              OP_CONJ: begin
                sv[0] = sat_acc(AW'($signed(q_item.a[0])));
                for (int c = 1; c < 4; c++) sv[c] = sat_acc(-AW'($signed(q_item.a[c])));
              end
              OP_EQ:   res_nxt.cmp = (q_item.a == q_item.b);
              OP_DIVS: begin
                if (q_item.f == '0) begin
                  res_nxt.st = ST_DIV0;
                end else begin
                  go_div    = 1'b1;
                  dv        = DW'(abs_w(q_item.f));
                  state_nxt = B_DIV;
                end
              end
              default: res_nxt = '0;
            endcase
            for (int c = 0; c < 4; c++) begin
              res_nxt.r[c] = sv[c].w;
              sat_any      = sat_any | sv[c].s;
            end
            if (sat_any) res_nxt.st = ST_SAT;
          end
        end
      end

      B_MAC: begin
        pv_nxt = 1'b1;
        for (int c = 0; c < 4; c++) begin
          ci = 2'(c);
          ti = cnt_r[1:0];
          pneg_nxt[c] = 1'b0;
          case (it_r.op)
            OP_MUL: begin
              mx          = it_r.a[ti];
              my          = it_r.b[ti ^ ci];
              pneg_nxt[c] = ham_neg(ti, ci);
            end
            OP_SCALE: begin
              mx = it_r.a[c];
              my = it_r.f;
            end
            OP_GE, OP_LE, OP_GT, OP_LT: begin
              mx          = (ti == 2'd0) ? it_r.a[c] : it_r.b[c];
              my          = mx;
              pneg_nxt[c] = (ti != 2'd0);
            end
            default: begin
              mx = it_r.a[c];
              my = it_r.a[c];
            end
          endcase
          p_nxt[c] = mx * my;
        end
        if (cnt_r[1:0] == it_r.ctl.last) state_nxt = B_DRAIN;
        else cnt_nxt = cnt_r + CW'(1);
      end

      B_DRAIN: state_nxt = B_SUM;

      B_SUM: begin
        if (it_r.ctl.sum) begin
          tot_nxt   = acc_r[0] + acc_r[1] + acc_r[2] + acc_r[3];
          state_nxt = B_POST;
        end else begin
          for (int c = 0; c < 4; c++) begin
            sv[c]        = sat_acc(acc_r[c] >>> FRAC);
            res_nxt.r[c] = sv[c].w;
            sat_any      = sat_any | sv[c].s;
          end
          if (sat_any) res_nxt.st = ST_SAT;
          state_nxt = B_OUT;
        end
      end

      B_POST: begin
        state_nxt = B_OUT;
        if (it_r.ctl.root) begin
          rad_nxt   = tot_r[SW-1:0];
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = B_ROOT;
        end else begin
          case (it_r.op)
            OP_NORM: begin
              sv[0]        = sat_acc(tot_r >>> FRAC);
              res_nxt.r[0] = sv[0].w;
              if (sv[0].s) res_nxt.st = ST_SAT;
            end
            OP_INV: begin
              if (tot_r == '0) begin
                res_nxt.st = ST_DIV0;
              end else begin
                go_div    = 1'b1;
                dshift2   = 1'b1;
                dv        = tot_r[DW-1:0];
                state_nxt = B_DIV;
              end
            end
            OP_GE: res_nxt.cmp = !tot_r[AW-1];
            OP_LE: res_nxt.cmp = tot_r[AW-1] || (tot_r == '0);
            OP_GT: res_nxt.cmp = !tot_r[AW-1] && (tot_r != '0);
            OP_LT: res_nxt.cmp = tot_r[AW-1];
            default: res_nxt = '0;
          endcase
        end
      end

      B_ROOT: begin
        remx  = {rem_r[RW:0], rad_r[SW-1 -: 2]};
        trial = {1'b0, root_r, 2'b01};
        if (remx >= trial) begin
          rem_nxt  = remx - trial;
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = remx;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        rad_nxt = rad_r << 2;
        if (cnt_r == CW'(RW - 1)) state_nxt = B_RDONE;
        else cnt_nxt = cnt_r + CW'(1);
      end

      B_RDONE: begin
        state_nxt = B_OUT;
        if (it_r.op == OP_LEN) begin
          sv[0]        = sat_acc($signed({{(AW-RW){1'b0}}, root_r}));
          res_nxt.r[0] = sv[0].w;
          if (sv[0].s) res_nxt.st = ST_SAT;
        end else if (root_r == '0) begin
          res_nxt.st = ST_DIV0;
        end else begin
          go_div    = 1'b1;
          dv        = DW'(root_r);
          state_nxt = B_DIV;
        end
      end

      B_DIV: begin
        for (int c = 0; c < 4; c++) begin
          rx = {drem_r[c], num_r[c][NW-1]};
          if (rx >= {1'b0, dvs_r}) begin
            drem_nxt[c] = DW'(rx - {1'b0, dvs_r});
            num_nxt[c]  = {num_r[c][NW-2:0], 1'b1};
          end else begin
            drem_nxt[c] = rx[DW-1:0];
            num_nxt[c]  = {num_r[c][NW-2:0], 1'b0};
          end
        end
        if (cnt_r == CW'(NW - 1)) state_nxt = B_DDONE;
        else cnt_nxt = cnt_r + CW'(1);
      end

      B_DDONE: begin
        for (int c = 0; c < 4; c++) begin
          sv[c] = sat_acc(dneg_r[c] ? -$signed(AW'(num_r[c])) : $signed(AW'(num_r[c])));
          res_nxt.r[c] = sv[c].w;
          sat_any      = sat_any | sv[c].s;
        end
        if (sat_any) res_nxt.st = ST_SAT;
        state_nxt = B_OUT;
      end

      B_OUT: begin
        if (!ov_r || out_if.ready) state_nxt = B_IDLE;
      end

      default: state_nxt = B_IDLE;
    endcase

    // divider setup, shared by divide-by-scalar, normalize and inverse
    if (go_div) begin
      dvs_nxt = dv;
      cnt_nxt = '0;
      for (int c = 0; c < 4; c++) begin
        mag         = (state_r == B_IDLE) ? abs_w(q_item.a[c]) : abs_w(it_r.a[c]);
        drem_nxt[c] = '0;
        num_nxt[c]  = dshift2 ? {mag, {(2*FRAC){1'b0}}} :
                                {{(NW-W-FRAC){1'b0}}, mag, {FRAC{1'b0}}};
        if (state_r == B_IDLE)
          dneg_nxt[c] = q_item.a[c][W-1] ^ q_item.f[W-1];
        else if (dshift2 && c != 0)
          dneg_nxt[c] = !it_r.a[c][W-1] && (it_r.a[c] != '0);
        else
          dneg_nxt[c] = it_r.a[c][W-1];
      end
    end

    load_out = (state_r == B_OUT) && (!ov_r || out_if.ready);
    ov_nxt   = load_out ? 1'b1 : (out_if.ready ? 1'b0 : ov_r);
    out_nxt  = load_out ? res_r : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r   <= it_nxt;
    cnt_r  <= cnt_nxt;
    tot_r  <= tot_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    dvs_r  <= dvs_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    for (int c = 0; c < 4; c++) begin
      p_r[c]    <= p_nxt[c];
      pneg_r[c] <= pneg_nxt[c];
      acc_r[c]  <= acc_nxt[c];
      num_r[c]  <= num_nxt[c];
      dneg_r[c] <= dneg_nxt[c];
      drem_r[c] <= drem_nxt[c];
    end
  end

  assign out_if.valid         = ov_r;
  assign out_if.r_scalar_part = out_r.r[0];
  assign out_if.r_i_part      = out_r.r[1];
  assign out_if.r_j_part      = out_r.r[2];
  assign out_if.r_k_part      = out_r.r[3];
  assign out_if.compare_true  = out_r.cmp;
  assign out_if.status        = out_r.st;

  `QALU_CHK(a_mac_steps, (state_r != B_MAC) || (cnt_r <= CW'(3)), "MAC step overrun")
  `QALU_CHK_NEXT(a_div_end, state_r == B_DIV && cnt_r == CW'(NW - 1), state_r == B_DDONE, "divider did not finish")
  `QALU_CHK(a_div0_zero, (state_r != B_OUT) || (res_r.st != ST_DIV0) || (res_r.r == '0 && !res_r.cmp), "div0 result not cleared")
  `QALU_CHK_NEXT(a_take_idle, q_take, state_r != B_IDLE, "back end took a word but stayed idle")

endmodule

/* rtl/quaternion_alu.sv */
// Quaternion ALU top level, signed Q16.16: front queue plus back-end sequencer.
// Depends on qalu_pkg, qalu_if, qalu_front, qalu_back.
//
//   channel | dir | handshake          | word
//   in_if   | in  | valid/ready        | action, A, B, factor
//   out_if  | out | valid/ready        | result quaternion, compare_true, status
//
// Input words are accepted every cycle while the 2-deep front queue has room.
// Back end takes one word at a time: add/sub/conj/eq skip the MAC lanes;
// length adds the root, divide-by-scalar and inverse the divider, normalize
// both (root one bit a cycle, divider one quotient bit a cycle).
// rst_n is synchronous, active low; it clears control state only.
// A stalled output holds its word in the output register; the back end then
// waits, and the front queue keeps taking words until full.
module quaternion_alu (
  input logic        clk,
  input logic        rst_n,
  qalu_in_if.sink    in_if,
  qalu_out_if.source out_if
);
  import qalu_pkg::*;

  // queue head between front and back
  logic  q_valid;
  item_t q_item;
  logic  q_take;

  qalu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  // multiplier lanes, root and divide iterations, output register
  qalu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take),
    .out_if  (out_if)
  );

endmodule

/* verif/tb_quaternion_alu.sv */
// Self-checking testbench for quaternion_alu: directed plus random operand words.
// Depends on qalu_pkg, qalu_if and the quaternion_alu RTL.
`timescale 1ns / 100ps

module tb_quaternion_alu;
  import qalu_pkg::*;

  // Wide enough for the shifted inverse numerator and all product sums.
  typedef logic signed [129:0] acc_t;

  typedef struct {
    op_t                 op;
    logic signed [W-1:0] a[4];
    logic signed [W-1:0] b[4];
    logic signed [W-1:0] f;
  } op_word_t;

  typedef struct {
    logic [W-1:0] r[4];
    logic         cmp;
    status_t      st;
  } res_word_t;

  localparam int N_RANDOM   = 880;
  localparam int WDOG_LIMIT = 6000;
  localparam int HOLD_LEN   = 400;

  logic clk;
  logic rst_n;

  qalu_in_if  in_if ();
  qalu_out_if out_if ();

  quaternion_alu uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  op_word_t  pending_words[$];
  res_word_t expected_results[$];
  int        n_errors;
  int        n_accepted;
  int        idle_cycles;
  int        hold_cnt;
  bit        hold_done;
  bit        stim_done;
  logic      in_taken;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Clamp to the word range; flags saturation.
  function automatic logic [W-1:0] clamp_word(input acc_t v, inout bit s);
    if (v > acc_t'(32'sh7fffffff)) begin
      s = 1'b1;
      return 32'h7fffffff;
    end else if (v < acc_t'(-33'sd2147483648)) begin
      s = 1'b1;
      return 32'h80000000;
    end
    return v[W-1:0];
  endfunction

  // Floor of the square root of a non-negative value below 2**82.
  function automatic acc_t floor_sqrt(input acc_t n);
    logic [129:0] root;
    logic [129:0] trial;
    root = '0;
    for (int i = 40; i >= 0; i--) begin
      trial = root | (130'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return acc_t'(root);
  endfunction

  function automatic acc_t sum_squares(input acc_t q[4]);
    return q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3];
  endfunction

  function automatic res_word_t compute_result(input op_word_t w);
    res_word_t res;
    acc_t      a[4];
    acc_t      b[4];
    acc_t      f;
    acc_t      t[4];
    acc_t      na;
    acc_t      nb;
    acc_t      len;
    bit        s;
    bit        div0;
    s    = 1'b0;
    div0 = 1'b0;
    res.cmp = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = acc_t'(w.a[i]);
      b[i] = acc_t'(w.b[i]);
      t[i] = '0;
    end
    f = acc_t'(w.f);
    case (w.op)
      OP_ADD: for (int i = 0; i < 4; i++) t[i] = a[i] + b[i];
      OP_SUB: for (int i = 0; i < 4; i++) t[i] = a[i] - b[i];
      OP_MUL: begin
        t[0] = (a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3]) >>> FRAC;
        t[1] = (a[0] * b[1] + b[0] * a[1] + a[2] * b[3] - a[3] * b[2]) >>> FRAC;
        t[2] = (a[0] * b[2] + b[0] * a[2] + a[3] * b[1] - a[1] * b[3]) >>> FRAC;
        t[3] = (a[0] * b[3] + b[0] * a[3] + a[1] * b[2] - a[2] * b[1]) >>> FRAC;
      end
      OP_SCALE: for (int i = 0; i < 4; i++) t[i] = (a[i] * f) >>> FRAC;
      OP_DIVS: begin
        if (f == 0) div0 = 1'b1;
        else for (int i = 0; i < 4; i++) t[i] = (a[i] <<< FRAC) / f;
      end
      OP_CONJ: begin
        t[0] = a[0];
        for (int i = 1; i < 4; i++) t[i] = -a[i];
      end
      OP_NORM: t[0] = sum_squares(a) >>> FRAC;
      OP_LEN:  t[0] = floor_sqrt(sum_squares(a));
      OP_NRMZ: begin
        len = floor_sqrt(sum_squares(a));
        if (len == 0) div0 = 1'b1;
        else for (int i = 0; i < 4; i++) t[i] = (a[i] <<< FRAC) / len;
      end
      OP_INV: begin
        na = sum_squares(a);
        if (na == 0) div0 = 1'b1;
        else for (int i = 0; i < 4; i++)
          t[i] = ((i == 0 ? a[i] : -a[i]) <<< (2 * FRAC)) / na;
      end
      OP_EQ: res.cmp = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]) && (a[3] == b[3]);
      OP_GE, OP_LE, OP_GT, OP_LT: begin
        na = sum_squares(a);
        nb = sum_squares(b);
        case (w.op)
          OP_GE:   res.cmp = na >= nb;
          OP_LE:   res.cmp = na <= nb;
          OP_GT:   res.cmp = na > nb;
          default: res.cmp = na < nb;
        endcase
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) res.r[i] = div0 ? '0 : clamp_word(t[i], s);
    res.st = div0 ? ST_DIV0 : (s ? ST_SAT : ST_OK);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly modest magnitudes, with zeros, extremes and full-range words mixed in.
  function automatic logic signed [W-1:0] pick_part();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: return W'($signed(v[19:0]));
      3:       return W'($signed(v[24:0]));
      4:       return '0;
      5: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh00010000;
          default: return -32'sh00010000;
        endcase
      end
      default: return v;
    endcase
  endfunction

  function automatic op_word_t random_word();
    op_word_t w;
    w.op = op_t'($urandom_range(0, 15));
    for (int i = 0; i < 4; i++) begin
      w.a[i] = pick_part();
      w.b[i] = pick_part();
    end
    w.f = pick_part();
    case ($urandom_range(0, 9))
      0: w.b = w.a;                                   // equal operands
      1: for (int i = 0; i < 4; i++) w.a[i] = '0;     // zero quaternion
      2: w.f = '0;                                    // zero divisor
      3: for (int i = 0; i < 4; i++) w.b[i] = -w.a[i]; // same norm, other sign
      default: ;
    endcase
    return w;
  endfunction

  function automatic op_word_t fill_word(input op_t op, input logic signed [W-1:0] av,
                                         input logic signed [W-1:0] bv,
                                         input logic signed [W-1:0] fv);
    op_word_t w;
    w.op = op;
    for (int i = 0; i < 4; i++) begin
      w.a[i] = av;
      w.b[i] = bv;
    end
    w.f = fv;
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset and stimulus
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    op_word_t w;
    rst_n = 1'b0;
    // Directed: every action, extremes, zero divisors, equality, saturation.
    for (int op = 0; op < 16; op++)
      pending_words.push_back(fill_word(op_t'(op), 32'sh00018000, -32'sh00008000,
                                        32'sh00020000));
    pending_words.push_back(fill_word(OP_ADD, 32'sh7fffffff, 32'sh7fffffff, '0));
    pending_words.push_back(fill_word(OP_SUB, 32'sh80000000, 32'sh7fffffff, '0));
    pending_words.push_back(fill_word(OP_CONJ, 32'sh80000000, '0, '0));
    pending_words.push_back(fill_word(OP_MUL, 32'sh80000000, 32'sh80000000, '0));
    pending_words.push_back(fill_word(OP_DIVS, 32'sh7fffffff, '0, '0));
    pending_words.push_back(fill_word(OP_DIVS, 32'sh80000000, '0, 32'sh00000001));
    pending_words.push_back(fill_word(OP_NRMZ, '0, '0, '0));
    pending_words.push_back(fill_word(OP_INV, '0, '0, '0));
    pending_words.push_back(fill_word(OP_INV, 32'sh00000001, '0, '0));
    pending_words.push_back(fill_word(OP_LEN, 32'sh80000000, '0, '0));
    w = fill_word(OP_EQ, 32'sh12345678, 32'sh12345678, '0);
    w.b[3] = 32'sh12345679;
    pending_words.push_back(w);
    for (int i = 0; i < N_RANDOM; i++) pending_words.push_back(random_word());
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------------
  // Driver: sender idles by phase; a word stays up until taken.
  // ---------------------------------------------------------------------

  always @(posedge clk) in_taken <= in_if.valid && in_if.ready;

  initial begin
    in_if.valid = 1'b0;
    in_if.action = '0;
    {in_if.a_scalar_part, in_if.a_i_part, in_if.a_j_part, in_if.a_k_part} = '0;
    {in_if.b_scalar_part, in_if.b_i_part, in_if.b_j_part, in_if.b_k_part} = '0;
    in_if.factor = '0;
    out_if.ready = 1'b0;
    in_taken = 1'b0;
    n_errors = 0;
    n_accepted = 0;
    idle_cycles = 0;
    hold_cnt = 0;
    hold_done = 1'b0;
    stim_done = 1'b0;
  end

  always @(negedge clk) begin
    int idle_pct;
    op_word_t w;
    idle_pct = n_accepted < 300 ? 30 : (n_accepted < 600 ? 64 : 0);
    if (in_taken && pending_words.size() > 0) void'(pending_words.pop_front());
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      // hold the offered word
    end else if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      w = pending_words[0];
      in_if.valid         <= 1'b1;
      in_if.action        <= w.op;
      in_if.a_scalar_part <= w.a[0];
      in_if.a_i_part      <= w.a[1];
      in_if.a_j_part      <= w.a[2];
      in_if.a_k_part      <= w.a[3];
      in_if.b_scalar_part <= w.b[0];
      in_if.b_i_part      <= w.b[1];
      in_if.b_j_part      <= w.b[2];
      in_if.b_k_part      <= w.b[3];
      in_if.factor        <= w.f;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Receiver: stalls by phase, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    int stall_pct;
    stall_pct = n_accepted < 300 ? 64 : (n_accepted < 600 ? 30 : 0);
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && n_accepted >= 150) begin
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and checks
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    n_errors++;
    $display("%0t: %s mismatch: got %h, want %h", $time, field, got, want);
  endtask

  always @(posedge clk) begin
    res_word_t exp_res;
    op_word_t  w;
    if (rst_n && in_if.valid && in_if.ready) begin
      w.op = op_t'(in_if.action);
      w.a[0] = in_if.a_scalar_part;
      w.a[1] = in_if.a_i_part;
      w.a[2] = in_if.a_j_part;
      w.a[3] = in_if.a_k_part;
      w.b[0] = in_if.b_scalar_part;
      w.b[1] = in_if.b_i_part;
      w.b[2] = in_if.b_j_part;
      w.b[3] = in_if.b_k_part;
      w.f = in_if.factor;
      expected_results.push_back(compute_result(w));
      n_accepted++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word", out_if.r_scalar_part, '0);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_if.r_scalar_part !== exp_res.r[0])
          report_mismatch("r_scalar_part", out_if.r_scalar_part, exp_res.r[0]);
        if (out_if.r_i_part !== exp_res.r[1])
          report_mismatch("r_i_part", out_if.r_i_part, exp_res.r[1]);
        if (out_if.r_j_part !== exp_res.r[2])
          report_mismatch("r_j_part", out_if.r_j_part, exp_res.r[2]);
        if (out_if.r_k_part !== exp_res.r[3])
          report_mismatch("r_k_part", out_if.r_k_part, exp_res.r[3]);
        if (out_if.compare_true !== exp_res.cmp)
          report_mismatch("compare_true", W'(out_if.compare_true), W'(exp_res.cmp));
        if (out_if.status !== exp_res.st)
          report_mismatch("status", W'(out_if.status), W'(exp_res.st));
      end
    end
  end

  // Watchdog: cycles with no word moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // End of run: all words sent and every result back, then drain.
  initial begin
    wait (stim_done);
    while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
